### sv/kcm_pkg.sv
// shared types and constants for the keyed count multiset table
// no dependencies; imported by every module of the block except kcm_ram
package kcm_pkg;

  localparam int COUNT_W      = 32;
  localparam int KEY_IN_W     = 16;
  localparam int REQ_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_SUB    = 2'd1,
    REQ_SCALE  = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  // classified command as it travels through the queue
  typedef struct packed {
    req_t               op;
    logic [COUNT_W-1:0] amount;
  } cmd_t;

  // queue fill flags seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### sv/kcm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module kcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/kcm_front.sv
// front end: accepts items, classifies them and hands them to the queue
// depends on kcm_pkg
module kcm_front import kcm_pkg::*; #(
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [KEY_IN_W-1:0] key,
  input  logic [COUNT_W-1:0]  amount,
  input  q_stat_t             q_stat,
  output logic                q_push,
  output cmd_t                q_cmd,
  output logic [KEY_BITS-1:0] q_key
);

  logic                f_valid;
  cmd_t                f_cmd;
  logic [KEY_BITS-1:0] f_key;
  cmd_t                cmd_next;
  logic [KEY_BITS-1:0] key_next;
  logic                take;

  assign q_push   = f_valid && !q_stat.full;
  assign in_stall = f_valid && q_stat.full;
  assign take     = in_valid && !in_stall;
  assign q_cmd    = f_cmd;
  assign q_key    = f_key;

  // scale ignores the key, lookup ignores the amount
  always_comb begin
    cmd_next.op     = req_t'(req_type);
    cmd_next.amount = (cmd_next.op == REQ_LOOKUP) ? '0 : amount;
    key_next        = (cmd_next.op == REQ_SCALE) ? '0 : KEY_BITS'(key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_cmd <= cmd_next;
      f_key <= key_next;
    end
  end

endmodule

### sv/kcm_queue.sv
// short fifo between the front end and the execution back end
// depends on kcm_pkg
module kcm_queue import kcm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output q_stat_t          stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign rdata      = slots[rd_ptr];
  assign stat.full  = (fill == CW'(DEPTH));
  assign stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

### sv/kcm_back.sv
// back end: key match, count update, scale sweep and output register
// depends on kcm_pkg and kcm_ram
module kcm_back import kcm_pkg::*; #(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  q_stat_t             q_stat,
  output logic                q_pop,
  input  cmd_t                q_cmd,
  input  logic [KEY_BITS-1:0] q_key,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  count_out,
  output logic [STATUS_W-1:0] status
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MATCH = 7'b0000010,
    S_FIND  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CALC  = 7'b0010000,
    S_SCALE = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  cmd_t                   cur_cmd;
  logic [KEY_BITS-1:0]    cur_key;
  logic [KEY_BITS-1:0]    entry_keys [ENTRIES];
  logic [CNT_W-1:0]       used_entries;
  logic [ENTRIES-1:0]     hit;
  logic [ENTRIES-1:0]     hit_q;
  logic [IDX_W-1:0]       slot_enc;
  logic [IDX_W-1:0]       slot;
  logic                   found;
  logic [CNT_W-1:0]       rd_idx;
  logic                   v1;
  logic                   v2;
  logic [IDX_W-1:0]       idx1;
  logic [IDX_W-1:0]       idx2;
  logic [2*COUNT_W-1:0]   prod;
  logic                   ovf;
  logic [COUNT_W-1:0]     res_cnt;
  status_t                res_st;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [COUNT_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [COUNT_W-1:0]     rdata;

  logic                   has_room;
  logic [IDX_W-1:0]       new_idx;
  logic [COUNT_W:0]       sum;
  logic [COUNT_W-1:0]     sum_sat;
  logic [COUNT_W-1:0]     sub_val;
  logic                   issue;
  logic                   scale_done;
  logic                   prod_sat;
  logic                   out_free;

  logic                   calc_we;
  logic                   calc_alloc;
  logic [IDX_W-1:0]       calc_waddr;
  logic [COUNT_W-1:0]     calc_wdata;
  logic [COUNT_W-1:0]     calc_cnt;
  status_t                calc_st;

  kcm_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (ENTRIES)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // parallel compare against every occupied slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = (CNT_W'(i) < used_entries) && (entry_keys[i] == cur_key);
    end
  end

  // keys are distinct, so at most one hit bit is set
  always_comb begin
    slot_enc = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_q[i]) begin
        slot_enc = slot_enc | IDX_W'(i);
      end
    end
  end

  assign has_room   = used_entries < CNT_W'(ENTRIES);
  assign new_idx    = used_entries[IDX_W-1:0];
  assign sum        = {1'b0, rdata} + {1'b0, cur_cmd.amount};
  assign sum_sat    = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
  assign sub_val    = (cur_cmd.amount >= rdata) ? '0 : rdata - cur_cmd.amount;
  assign issue      = rd_idx < used_entries;
  assign scale_done = !issue && !v1 && !v2;
  assign prod_sat   = |prod[2*COUNT_W-1:COUNT_W];
  assign out_free   = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && !q_stat.empty;

  always_comb begin
    calc_we    = 1'b0;
    calc_alloc = 1'b0;
    calc_waddr = slot;
    calc_wdata = '0;
    calc_cnt   = '0;
    calc_st    = ST_OK;
    case (cur_cmd.op)
      REQ_ADD: begin
        if (found) begin
          calc_we    = 1'b1;
          calc_wdata = sum_sat;
          calc_cnt   = sum_sat;
          calc_st    = sum[COUNT_W] ? ST_OVF : ST_OK;
        end else if (has_room) begin
          calc_we    = 1'b1;
          calc_alloc = 1'b1;
          calc_waddr = new_idx;
          calc_wdata = cur_cmd.amount;
          calc_cnt   = cur_cmd.amount;
        end else begin
          calc_st    = ST_FULL;
        end
      end
      REQ_SUB: begin
        if (found) begin
          calc_we    = 1'b1;
          calc_wdata = sub_val;
          calc_cnt   = sub_val;
        end
      end
      REQ_LOOKUP: begin
        if (found) begin
          calc_cnt = rdata;
        end
      end
      default: begin
        calc_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (state == S_SCALE) begin
      ram_we    = v2;
      ram_waddr = idx2;
      ram_wdata = prod_sat ? COUNT_MAX : prod[COUNT_W-1:0];
      ram_raddr = rd_idx[IDX_W-1:0];
    end else begin
      ram_we    = (state == S_CALC) && calc_we;
      ram_waddr = calc_waddr;
      ram_wdata = calc_wdata;
      ram_raddr = slot;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!q_stat.empty) begin
          state_next = (q_cmd.op == REQ_SCALE) ? S_SCALE : S_MATCH;
        end
      end
      S_MATCH: state_next = S_FIND;
      S_FIND:  state_next = S_READ;
      S_READ:  state_next = S_CALC;
      S_CALC:  state_next = S_EMIT;
      S_SCALE: begin
        if (scale_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used_entries <= '0;
      out_valid    <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CALC && calc_alloc) begin
        used_entries <= used_entries + 1'b1;
      end
      if (state == S_SCALE) begin
        v1 <= issue;
        v2 <= v1;
      end else begin
        v1 <= 1'b0;
        v2 <= 1'b0;
      end
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cmd <= q_cmd;
      cur_key <= q_key;
      rd_idx  <= '0;
      ovf     <= 1'b0;
    end
    if (state == S_MATCH) begin
      hit_q <= hit;
    end
    if (state == S_FIND) begin
      slot  <= slot_enc;
      found <= |hit_q;
    end
    if (state == S_CALC) begin
      res_cnt <= calc_cnt;
      res_st  <= calc_st;
      if (calc_alloc) begin
        entry_keys[new_idx] <= cur_key;
      end
    end
    // scale sweep: read, multiply, saturate and write back, one entry a cycle
    if (state == S_SCALE) begin
      rd_idx <= rd_idx + CNT_W'(issue);
      idx1   <= rd_idx[IDX_W-1:0];
      idx2   <= idx1;
      prod   <= rdata * cur_cmd.amount;
      if (v2 && prod_sat) begin
        ovf <= 1'b1;
      end
      if (scale_done) begin
        res_cnt <= '0;
        res_st  <= ovf ? ST_OVF : ST_OK;
      end
    end
    if (state == S_EMIT && out_free) begin
      count_out <= res_cnt;
      status    <= res_st;
    end
  end

endmodule

### sv/keyed_count_multiset_table.sv
// keyed count multiset table: add, subtract and lookup pass through the front register, the
// queue and the match, encode, ram read, update and output steps (front register, queue, match,
// encode, ram read, update, output); scale runs a sweep over the used entries in place of match
// through update. one item at a time in the back end: it takes no new item from the queue until
// the result of the last one has left the emit state, set by the back-end sequencer.
// reset is synchronous: the table is emptied and the queue and output cleared; no clear pass.
module keyed_count_multiset_table import kcm_pkg::*; #(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [KEY_IN_W-1:0] key,
  input  logic [COUNT_W-1:0]  amount,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  count_out,
  output logic [STATUS_W-1:0] status
);

  // one queued item is the classified command plus the masked key
  localparam int ITEM_W = $bits(cmd_t) + KEY_BITS;

  q_stat_t             q_stat;
  logic                q_push;
  logic                q_pop;
  cmd_t                f_cmd;
  logic [KEY_BITS-1:0] f_key;
  logic [ITEM_W-1:0]   q_wdata;
  logic [ITEM_W-1:0]   q_rdata;
  cmd_t                bk_cmd;
  logic [KEY_BITS-1:0] bk_key;

  // front end: takes items as long as its holding register can drain into the queue
  kcm_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .key      (key),
    .amount   (amount),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (f_cmd),
    .q_key    (f_key)
  );

  assign q_wdata = {f_cmd, f_key};

  // queue decouples acceptance from execution
  kcm_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  assign {bk_cmd, bk_key} = q_rdata;

  // back end: key search, count update or scale sweep, then the output register
  kcm_back #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .q_cmd     (bk_cmd),
    .q_key     (bk_key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .count_out (count_out),
    .status    (status)
  );

  // the back end never pops an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_stat.empty)
    else $error("back end popped an empty queue");

  // a miss on a full table reports no count
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count_out == '0))
    else $error("table full result carries a count");

  // status code three is never produced
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3))
    else $error("undefined status code on output");

  // reset leaves the queue empty and no result pending
  assert property (@(posedge clk) (!rst && $past(rst)) |-> (!out_valid && q_stat.empty))
    else $error("state left over after reset");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for keyed_count_multiset_table: directed and random requests
// against an in-bench model of the count table; depends on kcm_pkg and the block only
module testbench;
  import kcm_pkg::*;

  localparam int ENTRIES     = DEF_ENTRIES;
  localparam int KEY_BITS    = DEF_KEY_BITS;
  localparam int POOL_SIZE   = 24;      // more keys than slots so the table fills up
  localparam int PHASE_ITEMS = 250;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    req_t               op;
    logic [KEY_IN_W-1:0] key;
    logic [COUNT_W-1:0]  amount;
  } request_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    status_t            status;
  } result_t;

  // clock and reset
  logic clk;
  logic rst = 1'b1;

  // block inputs, all known from time zero
  logic                in_valid  = 1'b0;
  logic [REQ_W-1:0]    req_type  = '0;
  logic [KEY_IN_W-1:0] key       = '0;
  logic [COUNT_W-1:0]  amount    = '0;
  logic                out_stall = 1'b0;

  // block outputs
  logic                in_stall;
  logic                out_valid;
  logic [COUNT_W-1:0]  count_out;
  logic [STATUS_W-1:0] status;

  // model of the table contents
  logic [KEY_BITS-1:0] slot_keys   [ENTRIES];
  logic [COUNT_W-1:0]  slot_counts [ENTRIES];
  int                  slots_used = 0;

  request_t            req_queue[$];          // requests waiting to be presented
  result_t             expected_results[$];   // predicted results, oldest first
  logic [KEY_IN_W-1:0] key_pool[POOL_SIZE];

  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     item_taken = 1'b0;   // input item accepted at the last rising edge
  int       mismatch_count = 0;
  int       cycle_count = 0;
  request_t next_req;
  result_t  pred, got;

  keyed_count_multiset_table DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .key       (key),
    .amount    (amount),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .count_out (count_out),
    .status    (status)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // one request against the model table: updates the table and returns the result
  task automatic apply_request(input request_t r, output result_t res);
    logic [KEY_BITS-1:0] k;
    logic [63:0]         wide;
    logic [COUNT_W-1:0]  c;
    int                  slot;
    k          = r.key[KEY_BITS-1:0];
    slot       = -1;
    res.count  = '0;
    res.status = ST_OK;
    if (r.op == REQ_SCALE) begin
      // every occupied count is multiplied, saturating at the top
      for (int i = 0; i < slots_used; i++) begin
        wide = {32'd0, slot_counts[i]} * {32'd0, r.amount};
        if (wide > {32'd0, COUNT_MAX}) begin
          wide       = {32'd0, COUNT_MAX};
          res.status = ST_OVF;
        end
        slot_counts[i] = wide[COUNT_W-1:0];
      end
    end else begin
      for (int i = 0; i < slots_used; i++)
        if (slot < 0 && slot_keys[i] == k) slot = i;
      case (r.op)
        REQ_ADD: begin
          // a miss takes the next free slot, even for a zero amount
          if (slot < 0) begin
            if (slots_used < ENTRIES) begin
              slot              = slots_used;
              slot_keys[slot]   = k;
              slot_counts[slot] = '0;
              slots_used++;
            end else begin
              res.status = ST_FULL;
            end
          end
          if (slot >= 0) begin
            wide = {32'd0, slot_counts[slot]} + {32'd0, r.amount};
            if (wide > {32'd0, COUNT_MAX}) begin
              wide       = {32'd0, COUNT_MAX};
              res.status = ST_OVF;
            end
            slot_counts[slot] = wide[COUNT_W-1:0];
            res.count         = wide[COUNT_W-1:0];
          end
        end
        REQ_SUB: begin
          // floor at zero; an absent key is left alone
          if (slot >= 0) begin
            c                 = slot_counts[slot];
            c                 = (r.amount >= c) ? '0 : c - r.amount;
            slot_counts[slot] = c;
            res.count         = c;
          end
        end
        default: begin
          if (slot >= 0) res.count = slot_counts[slot];
        end
      endcase
    end
  endtask

  task automatic push_req(input req_t op, input logic [KEY_IN_W-1:0] k,
                          input logic [COUNT_W-1:0] amt);
    req_queue.insert(req_queue.size(), request_t'{op, k, amt});
  endtask

  // amounts lean toward small values but reach zero, the top and all bits
  function automatic logic [COUNT_W-1:0] pick_amount();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom_range(1000);
    if (sel < 55) return $urandom;
    if (sel < 65) return COUNT_MAX;
    if (sel < 75) return COUNT_MAX - $urandom_range(1000);
    if (sel < 85) return '0;
    return $urandom_range(32'h00ff_ffff);
  endfunction

  // scale factors mostly small so counts do not all pin at the top
  function automatic logic [COUNT_W-1:0] pick_factor();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return 32'd1;
    if (sel < 55) return $urandom_range(3);
    if (sel < 80) return $urandom_range(16, 2);
    return $urandom;
  endfunction

  function automatic request_t random_req();
    request_t r;
    int       sel;
    sel = $urandom_range(99);
    if (sel < 35)      r.op = REQ_ADD;
    else if (sel < 55) r.op = REQ_SUB;
    else if (sel < 63) r.op = REQ_SCALE;
    else               r.op = REQ_LOOKUP;
    // mostly keys from the pool so hits are common, some fully random keys
    if ($urandom_range(99) < 90) r.key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else                         r.key = KEY_IN_W'($urandom);
    r.amount = (r.op == REQ_SCALE) ? pick_factor() : pick_amount();
    return r;
  endfunction

  // wait until every queued request has been accepted
  task automatic wait_sent();
    do begin
      @(posedge clk);
      #1;
    end while (req_queue.size() != 0 || in_valid);
  endtask

  // driver: inputs change on the falling edge, a stalled item is held as is
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = req_queue.pop_front();
        in_valid <= 1'b1;
        req_type <= next_req.op;
        key      <= next_req.key;
        amount   <= next_req.amount;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= (!rst && $urandom_range(99) < recv_stall_pct);
  end

  // monitor: results are checked first, then an accepted item is predicted
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, count_out %h status %0d", $time, count_out, status);
        mismatch_count++;
      end else begin
        got = expected_results.pop_front();
        if (count_out !== got.count) begin
          $display("%0t: count_out mismatch, expected %h, actual %h",
                   $time, got.count, count_out);
          mismatch_count++;
        end
        if (status !== got.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, got.status, status);
          mismatch_count++;
        end
      end
    end
    item_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      apply_request('{req_t'(req_type), key, amount}, pred);
      expected_results.insert(expected_results.size(), pred);
    end
  end

  // watchdog on a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** keyed_count_multiset_table: FAILED **");
      $finish;
    end
  end

  // reset asserted from time zero, released on a falling edge
  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
  end

  // stimulus: directed requests, then four random phases with different idling
  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_IN_W'($urandom);

    // empty table: lookup, subtract and scale all see no entries
    push_req(REQ_LOOKUP, 16'h0000, COUNT_MAX);
    push_req(REQ_SUB,    16'h0000, 32'd5);
    push_req(REQ_SCALE,  16'h4321, COUNT_MAX);
    // zero amount still takes a slot
    push_req(REQ_ADD,    16'h0000, 32'd0);
    push_req(REQ_LOOKUP, 16'h0000, 32'd0);
    // add up to the top, then past it
    push_req(REQ_ADD,    16'hffff, COUNT_MAX);
    push_req(REQ_ADD,    16'hffff, 32'd1);
    push_req(REQ_ADD,    16'h1234, 32'd100);
    push_req(REQ_SUB,    16'h1234, 32'd30);
    // subtract floors at zero and the slot stays
    push_req(REQ_SUB,    16'h1234, COUNT_MAX);
    push_req(REQ_LOOKUP, 16'h1234, 32'd7);
    push_req(REQ_ADD,    16'h1234, 32'h0001_0000);
    // product 2^32 saturates
    push_req(REQ_SCALE,  16'h0000, 32'h0001_0000);
    push_req(REQ_LOOKUP, 16'h1234, 32'd0);
    push_req(REQ_SCALE,  16'hffff, 32'd1);
    // scale by zero clears every count
    push_req(REQ_SCALE,  16'h0000, 32'd0);
    push_req(REQ_LOOKUP, 16'hffff, 32'd0);
    push_req(REQ_LOOKUP, 16'h5555, 32'd0);
    push_req(REQ_ADD,    16'haaaa, 32'h5555_5555);
    push_req(REQ_ADD,    16'h5555, 32'haaaa_aaaa);
    wait_sent();

    // the random part fills the table early, so misses on a full table are common
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) req_queue.insert(req_queue.size(), random_req());
      wait_sent();
    end

    // drain the remaining results, then give stray ones time to show up
    while (expected_results.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    #1;
    if (mismatch_count == 0) begin
      $display("** keyed_count_multiset_table: PASSED **");
    end else begin
      $display("** keyed_count_multiset_table: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
sv/kcm_pkg.sv
sv/kcm_ram.sv
sv/kcm_front.sv
sv/kcm_queue.sv
sv/kcm_back.sv
sv/keyed_count_multiset_table.sv
dv/testbench.sv
